[design/udrb_pkg.sv]
package udrb_pkg;

   localparam int DATA_W   = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 4;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [DATA_W-1:0]   byte_type;

   localparam op_type OP_HOST_SEND = 2'd0;
   localparam op_type OP_HOST_READ = 2'd1;
   localparam op_type OP_TX_READY  = 2'd2;
   localparam op_type OP_RX_BYTE   = 2'd3;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_FULL    = 2'd1;
   localparam status_type STATUS_FRAMING = 2'd2;

   localparam byte_type NUL_BYTE = 8'h00;

   // ring occupancy flags seen by the control logic
   typedef struct packed {
      logic full;
      logic empty;
      logic one_left;
   } ring_flags_type;

   // per-word result bits held until the response is taken
   typedef struct packed {
      status_type status;
      logic       rx_popped;
      logic       line_valid;
      logic       tx_popped;
      logic       restart;
   } result_type;

endpackage

[design/udrb_req_if.sv]
interface udrb_req_if import udrb_pkg::*; ();
   logic     valid;
   logic     ready;
   op_type   operation;
   byte_type data_byte;
   logic     framing_error;
   logic     overrun;

   modport source (output valid, output operation, output data_byte,
                   output framing_error, output overrun, input ready);
   modport sink (input valid, input operation, input data_byte,
                 input framing_error, input overrun, output ready);
endinterface

[design/udrb_rsp_if.sv]
interface udrb_rsp_if import udrb_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   byte_type          read_data;
   logic              line_byte_valid;
   byte_type          line_byte;
   logic              tx_irq_enabled;
   logic              restart_receiver;
   logic [FILL_W-1:0] rx_fill;
   logic [FILL_W-1:0] tx_fill;

   modport source (output valid, output status, output read_data,
                   output line_byte_valid, output line_byte, output tx_irq_enabled,
                   output restart_receiver, output rx_fill, output tx_fill,
                   input ready);
   modport sink (input valid, input status, input read_data,
                 input line_byte_valid, input line_byte, input tx_irq_enabled,
                 input restart_receiver, input rx_fill, input tx_fill,
                 output ready);
endinterface

[design/uart_dual_ring_buffer.sv]
// UART data path with a transmit ring and a receive ring, RING_DEPTH bytes
// each, one slot kept free so a ring holds RING_DEPTH - 1 bytes.
// req channel: one word per event (host send, host read, transmitter ready,
// byte received) with its data byte and receiver error flags.
// rsp channel: exactly one word per request with status, popped bytes, the
// transmit interrupt enable and both fill levels after the event.
// The response is valid in the cycle after the request is accepted, since
// the ring stores have a registered read.
// Throughput: one word per cycle while the response side is ready; a new
// request is taken in the same cycle the pending response is taken, so at
// most one word is in flight.
// Stall: while rsp is held off, req ready stays low and the response holds.
// Reset: both rings empty and the transmit interrupt enable cleared; store
// contents are not cleared and are never read before being written.
module uart_dual_ring_buffer import udrb_pkg::*; #(
   parameter int RING_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   udrb_req_if.sink   req_ch,
   udrb_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(RING_DEPTH);

   logic             accept;
   logic             busy_ff, busy_in;
   logic             irq_ff, irq_in;
   result_type       res_ff, res_in;
   logic             tx_push, tx_pop, rx_push, rx_pop;
   ring_flags_type   tx_flags, rx_flags;
   logic [IDX_W-1:0] tx_fill, rx_fill;
   byte_type         tx_data, rx_data;

   assign req_ch.ready = !busy_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      res_in  = '0;
      irq_in  = irq_ff;
      tx_push = 1'b0;
      tx_pop  = 1'b0;
      rx_push = 1'b0;
      rx_pop  = 1'b0;
      unique case (req_ch.operation)
         OP_HOST_SEND: begin
            if (tx_flags.full) begin
               res_in.status = STATUS_FULL;
            end else begin
               tx_push = accept;
               irq_in  = 1'b1;
            end
         end
         OP_HOST_READ: begin
            res_in.rx_popped = !rx_flags.empty;
            rx_pop           = accept && !rx_flags.empty;
         end
         OP_TX_READY: begin
            if (irq_ff) begin
               res_in.line_valid = 1'b1;
               res_in.tx_popped  = !tx_flags.empty;
               tx_pop            = accept && !tx_flags.empty;
               irq_in            = !tx_flags.empty && !tx_flags.one_left;
            end
         end
         OP_RX_BYTE: begin
            res_in.restart = req_ch.overrun;
            if (req_ch.framing_error) begin
               res_in.status = STATUS_FRAMING;
            end else if (rx_flags.full) begin
               res_in.status = STATUS_FULL;
            end else begin
               rx_push = accept;
            end
         end
         default: begin
         end
      endcase
   end

   assign busy_in = accept || (busy_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         irq_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (accept) begin
            irq_ff <= irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   udrb_ring #(.DEPTH(RING_DEPTH), .IDX_W(IDX_W)) u_tx_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .pop       (tx_pop),
      .push_data (req_ch.data_byte),
      .flags     (tx_flags),
      .fill      (tx_fill),
      .pop_data  (tx_data)
   );

   udrb_ring #(.DEPTH(RING_DEPTH), .IDX_W(IDX_W)) u_rx_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .pop       (rx_pop),
      .push_data (req_ch.data_byte),
      .flags     (rx_flags),
      .fill      (rx_fill),
      .pop_data  (rx_data)
   );

   assign rsp_ch.valid            = busy_ff;
   assign rsp_ch.status           = res_ff.status;
   assign rsp_ch.read_data        = res_ff.rx_popped ? rx_data : NUL_BYTE;
   assign rsp_ch.line_byte_valid  = res_ff.line_valid;
   assign rsp_ch.line_byte        = res_ff.tx_popped ? tx_data : NUL_BYTE;
   assign rsp_ch.tx_irq_enabled   = irq_ff;
   assign rsp_ch.restart_receiver = res_ff.restart;
   assign rsp_ch.rx_fill          = FILL_W'(rx_fill);
   assign rsp_ch.tx_fill          = FILL_W'(tx_fill);

endmodule

[design/udrb_ring.sv]
module udrb_ring import udrb_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               pop,
   input  byte_type           push_data,
   output ring_flags_type     flags,
   output logic [IDX_W-1:0]   fill,
   output byte_type           pop_data
);

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);

   byte_type         mem [DEPTH];
   logic [IDX_W-1:0] wr_ff, wr_in;
   logic [IDX_W-1:0] rd_ff, rd_in;
   logic [IDX_W-1:0] wr_next, rd_next;
   logic [IDX_W:0]   diff;
   byte_type         pop_data_ff;

   assign wr_next = (wr_ff == LAST_IDX) ? '0 : wr_ff + 1'b1;
   assign rd_next = (rd_ff == LAST_IDX) ? '0 : rd_ff + 1'b1;

   assign flags.full     = (wr_next == rd_ff);
   assign flags.empty    = (wr_ff == rd_ff);
   assign flags.one_left = (rd_next == wr_ff);

   always_comb begin
      if (wr_ff >= rd_ff) begin
         diff = {1'b0, wr_ff} - {1'b0, rd_ff};
      end else begin
         diff = {1'b0, wr_ff} + DEPTH_EXT - {1'b0, rd_ff};
      end
   end
   assign fill = diff[IDX_W-1:0];

   assign wr_in = push ? wr_next : wr_ff;
   assign rd_in = pop ? rd_next : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   // store with one write and one read port usable together, read data registered
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
      if (pop) begin
         pop_data_ff <= mem[rd_ff];
      end
   end

   assign pop_data = pop_data_ff;

endmodule
